// ===== rtl/core/frt_pkg.sv =====
// Shared constants, codes and types of the fragment reassembly tracker.
// Used by frt_slot_pick and fragment_reassembly_tracker; depends on nothing.

package frt_pkg;

	localparam int SLOT_COUNT    = 6;
	localparam int MAX_FRAGMENTS = 64;

	localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int FRAG_W  = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int TOTAL_W = 7;
	localparam int SUM_W   = 18;

	localparam logic [15:0] EXPIRE_RESET = 16'd1500;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_RANGE     = 3'd2,
		ST_BAD_COUNT = 3'd3,
		ST_COMPLETE  = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	// Outcome of the slot search for one fragment.
	typedef struct packed {
		logic [SLOT_W-1:0]     idx;   // chosen slot
		logic                  fresh; // slot is newly taken, contents start empty
		logic [SLOT_COUNT-1:0] live;  // valid slots that survive expiry
	} pick_t;

endpackage

// ===== rtl/core/frt_slot_pick.sv =====
// Slot search of the fragment reassembly tracker: expiry, key match, free
// slot and oldest slot, all evaluated in parallel. Depends on frt_pkg.

module frt_slot_pick import frt_pkg::*; (
	input  logic [SLOT_COUNT-1:0]       valid,
	input  logic [SLOT_COUNT-1:0][15:0] seq,
	input  logic [SLOT_COUNT-1:0][15:0] source,
	input  logic [SLOT_COUNT-1:0][31:0] touch,
	input  logic [31:0]                 now_time,
	input  logic [15:0]                 msg_seq,
	input  logic [15:0]                 source_node,
	input  logic [15:0]                 expire_after,
	output pick_t                       pick
);

	logic [SLOT_COUNT-1:0][31:0] age;
	logic [SLOT_COUNT-1:0]       live;
	logic [SLOT_COUNT-1:0]       hit;
	logic [SLOT_COUNT-1:0]       oldest;
	logic [SLOT_W-1:0]           hit_idx;
	logic [SLOT_W-1:0]           free_idx;
	logic [SLOT_W-1:0]           old_idx;

	always_comb begin
		for (int k = 0; k < SLOT_COUNT; k++) begin
			age[k]  = now_time - touch[k];
			live[k] = valid[k] && !(age[k] > {16'd0, expire_after});
			hit[k]  = live[k] && (seq[k] == msg_seq) && (source[k] == source_node);
		end
		// A slot is the oldest when it beats every lower slot strictly and
		// every higher slot at least equally, so ties go to the lowest index.
		for (int k = 0; k < SLOT_COUNT; k++) begin
			oldest[k] = 1'b1;
			for (int j = 0; j < SLOT_COUNT; j++) begin
				if (j < k && !(age[k] > age[j]))
					oldest[k] = 1'b0;
				if (j > k && age[k] < age[j])
					oldest[k] = 1'b0;
			end
		end
		hit_idx  = '0;
		free_idx = '0;
		old_idx  = '0;
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			if (hit[k])
				hit_idx = SLOT_W'(k);
			if (!live[k])
				free_idx = SLOT_W'(k);
			if (oldest[k])
				old_idx = SLOT_W'(k);
		end
		pick.live = live;
		if (|hit) begin
			pick.idx   = hit_idx;
			pick.fresh = 1'b0;
		end else if (!(&live)) begin
			pick.idx   = free_idx;
			pick.fresh = 1'b1;
		end else begin
			pick.idx   = old_idx;
			pick.fresh = 1'b1;
		end
	end

endmodule

// ===== rtl/core/fragment_reassembly_tracker.sv =====
// Top level of the fragment reassembly tracker: input register, slot table,
// per-fragment update logic and result register. Depends on frt_pkg, frt_slot_pick.

// The tracker takes one fragment header per transaction and returns exactly
// one result transaction for it, loaded into the result register once that is
// free. A new header can be taken in every cycle while results are taken, so
// the sustained rate is one fragment per clock; the figure is set by the single
// registered pass from the input register through the parallel search over all
// slots to the slot table and the result register. The result register
// decouples the sides: a header still enters an empty input register while an
// earlier result waits. The idle limit is written through the cfg channel, which
// is always ready; it should only be changed while no fragment is in flight.

module fragment_reassembly_tracker import frt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// Fragment headers.
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] now_time, [47:32] msg_seq, [63:48] source_node,
	// [79:64] frag_index, [95:80] frag_total, [107:96] frag_length, rest zero.
	input  logic [111:0] s_tdata,
	// Results.
	output logic         m_tvalid,
	input  logic         m_tready,
	// [2:0] status, [5:3] slot_used, [23:6] message_length,
	// [30:24] fragment_count, [31] zero.
	output logic [31:0]  m_tdata,
	// Idle limit register.
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	// Input register.
	logic        in_valid_s1;
	logic [31:0] now_time_s1;
	logic [15:0] msg_seq_s1;
	logic [15:0] source_node_s1;
	logic [15:0] frag_index_s1;
	logic [15:0] frag_total_s1;
	logic [11:0] frag_length_s1;

	// Slot table. Only the valid bits are reset; the contents of a slot are
	// never looked at while it is free.
	logic [SLOT_COUNT-1:0]                    valid_q;
	logic [SLOT_COUNT-1:0][15:0]              seq_q;
	logic [SLOT_COUNT-1:0][15:0]              source_q;
	logic [SLOT_COUNT-1:0][TOTAL_W-1:0]       total_q;
	logic [SLOT_COUNT-1:0][TOTAL_W-1:0]       received_q;
	logic [SLOT_COUNT-1:0][31:0]              touch_q;
	logic [SLOT_COUNT-1:0][MAX_FRAGMENTS-1:0] present_q;
	logic [SLOT_COUNT-1:0][SUM_W-1:0]         sum_q;

	logic [15:0] expire_q;

	// Result register.
	logic              out_valid_q;
	status_t           status_q;
	logic [2:0]        slot_used_q;
	logic [SUM_W-1:0]  length_q;
	logic [TOTAL_W-1:0] count_q;

	logic advance;
	logic fire;
	pick_t pick;

	logic [TOTAL_W-1:0]       cur_total;
	logic [TOTAL_W-1:0]       cur_received;
	logic [MAX_FRAGMENTS-1:0] cur_present;
	logic [MAX_FRAGMENTS-1:0] new_present;
	logic [SUM_W-1:0]         cur_sum;
	logic                     total_ok;
	logic [TOTAL_W-1:0]       new_total;
	logic                     index_ok;
	logic [FRAG_W-1:0]        bit_idx;
	logic [TOTAL_W-1:0]       received_inc;
	logic [SUM_W-1:0]         sum_inc;
	status_t                  status;
	logic                     keep_slot;
	logic [SLOT_W+2:0]        slot_wide;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || m_tready;
	assign fire      = in_valid_s1 && advance;
	assign s_tready  = !in_valid_s1 || advance;

	frt_slot_pick u_pick (
		.valid       (valid_q),
		.seq         (seq_q),
		.source      (source_q),
		.touch       (touch_q),
		.now_time    (now_time_s1),
		.msg_seq     (msg_seq_s1),
		.source_node (source_node_s1),
		.expire_after(expire_q),
		.pick        (pick)
	);

	always_comb begin
		// A freshly taken slot starts empty whatever it held before.
		cur_total    = pick.fresh ? '0 : total_q[pick.idx];
		cur_received = pick.fresh ? '0 : received_q[pick.idx];
		cur_present  = pick.fresh ? '0 : present_q[pick.idx];
		cur_sum      = pick.fresh ? '0 : sum_q[pick.idx];

		total_ok = (frag_total_s1 != 16'd0) && (frag_total_s1 <= 16'(MAX_FRAGMENTS));

		// The first fragment fixes the count; later ones may only raise it.
		if (cur_total == '0)
			new_total = total_ok ? frag_total_s1[TOTAL_W-1:0] : '0;
		else if (total_ok && frag_total_s1 > {{(16 - TOTAL_W){1'b0}}, cur_total})
			new_total = frag_total_s1[TOTAL_W-1:0];
		else
			new_total = cur_total;

		index_ok     = frag_index_s1 < {{(16 - TOTAL_W){1'b0}}, new_total};
		bit_idx      = frag_index_s1[FRAG_W-1:0];
		received_inc = cur_received + TOTAL_W'(1);
		sum_inc      = cur_sum + {{(SUM_W - 12){1'b0}}, frag_length_s1};

		new_present          = cur_present;
		new_present[bit_idx] = 1'b1;

		priority if (frag_length_s1 == 12'd0)
			status = ST_EMPTY;
		else if (cur_total == '0 && !total_ok)
			status = ST_BAD_COUNT;
		else if (!index_ok)
			status = ST_RANGE;
		else if (cur_present[bit_idx])
			status = ST_DUPLICATE;
		else if (received_inc == new_total)
			status = ST_COMPLETE;
		else
			status = ST_STORED;

		// A dropped or completed message frees its slot.
		keep_slot = (status == ST_STORED) || (status == ST_DUPLICATE) ||
			(status == ST_RANGE);

		slot_wide = {3'd0, pick.idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expire_q <= EXPIRE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			expire_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_valid_s1 <= 1'b1;
		end else if (fire) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_time_s1    <= s_tdata[31:0];
			msg_seq_s1     <= s_tdata[47:32];
			source_node_s1 <= s_tdata[63:48];
			frag_index_s1  <= s_tdata[79:64];
			frag_total_s1  <= s_tdata[95:80];
			frag_length_s1 <= s_tdata[107:96];
		end
	end

	// Slot table update: expiry on all slots, then the chosen slot's new state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fire && status != ST_EMPTY) begin
			for (int k = 0; k < SLOT_COUNT; k++) begin
				if (SLOT_W'(k) == pick.idx)
					valid_q[k] <= keep_slot;
				else
					valid_q[k] <= pick.live[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && status != ST_EMPTY) begin
			seq_q[pick.idx]    <= msg_seq_s1;
			source_q[pick.idx] <= source_node_s1;
			touch_q[pick.idx]  <= now_time_s1;
			total_q[pick.idx]  <= new_total;
			if (status == ST_STORED) begin
				received_q[pick.idx] <= received_inc;
				present_q[pick.idx]  <= new_present;
				sum_q[pick.idx]      <= sum_inc;
			end else begin
				received_q[pick.idx] <= cur_received;
				present_q[pick.idx]  <= cur_present;
				sum_q[pick.idx]      <= cur_sum;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status;
			slot_used_q <= (status == ST_EMPTY) ? 3'd0 : slot_wide[2:0];
			length_q    <= (status == ST_COMPLETE) ? sum_inc : '0;
			count_q     <= (status == ST_COMPLETE) ? new_total : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, count_q, length_q, slot_used_q, status_q};

endmodule

// ===== sim/tb_fragment_reassembly_tracker.sv =====
// Self-checking testbench for fragment_reassembly_tracker: directed and random fragment
// traffic, a behavioural slot table predicting every result, and random flow control.
// Depends on frt_pkg and the fragment_reassembly_tracker RTL.

module tb_fragment_reassembly_tracker import frt_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	// One fragment header, packed so that now_time sits in the lowest bits as on s_tdata.
	typedef struct packed {
		logic [11:0] len;
		logic [15:0] tot;
		logic [15:0] idx;
		logic [15:0] src;
		logic [15:0] seq;
		logic [31:0] now;
	} frag_t;

	// One predicted result.
	typedef struct packed {
		status_t     status;
		logic [2:0]  slot;
		logic [17:0] msg_len;
		logic [6:0]  frag_cnt;
	} outcome_t;

	localparam int OPEN_MAX = 8;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	fragment_reassembly_tracker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// Behavioural copy of the slot table and the idle limit.
	logic [15:0] expire_limit;
	logic        tbl_valid   [SLOT_COUNT];
	logic [15:0] tbl_seq     [SLOT_COUNT];
	logic [15:0] tbl_src     [SLOT_COUNT];
	logic [6:0]  tbl_total   [SLOT_COUNT];
	logic [6:0]  tbl_rcvd    [SLOT_COUNT];
	logic [31:0] tbl_touch   [SLOT_COUNT];
	logic [63:0] tbl_present [SLOT_COUNT];
	logic [17:0] tbl_len_sum [SLOT_COUNT];

	outcome_t predicted_outcomes[$];
	int       fail_count = 0;

	// Flow control state shared between the tests and the two bus sides.
	int burst_left = 0;
	bit sender_steady = 1'b0;
	int rx_hold_req = 0;

	// Shaping of the random traffic: messages currently being sent.
	logic [31:0] clock_ms;
	int open_limit;
	int open_seq   [OPEN_MAX];
	int open_src   [OPEN_MAX];
	int open_tot   [OPEN_MAX];
	int open_pos   [OPEN_MAX];
	bit open_live  [OPEN_MAX];
	int open_order [OPEN_MAX][64];

	function automatic void clear_slot(int k);
		tbl_valid[k]   = 1'b0;
		tbl_seq[k]     = '0;
		tbl_src[k]     = '0;
		tbl_total[k]   = '0;
		tbl_rcvd[k]    = '0;
		tbl_touch[k]   = '0;
		tbl_present[k] = '0;
		tbl_len_sum[k] = '0;
	endfunction

	// Applies one fragment to the slot table and returns the result it causes.
	function automatic outcome_t track_fragment(frag_t f);
		outcome_t    o;
		int          pick;
		logic [31:0] age;
		logic [31:0] best_age;
		o.status   = ST_STORED;
		o.slot     = '0;
		o.msg_len  = '0;
		o.frag_cnt = '0;
		// An empty fragment leaves everything alone, expiry included.
		if (f.len == 0) begin
			o.status = ST_EMPTY;
			return o;
		end
		for (int k = 0; k < SLOT_COUNT; k++) begin
			age = f.now - tbl_touch[k];
			if (tbl_valid[k] && age > {16'd0, expire_limit})
				clear_slot(k);
		end
		// Matching key first, then the lowest free slot, then the stalest one.
		pick = -1;
		for (int k = 0; k < SLOT_COUNT; k++)
			if (pick < 0 && tbl_valid[k] && tbl_seq[k] == f.seq && tbl_src[k] == f.src)
				pick = k;
		if (pick < 0) begin
			for (int k = 0; k < SLOT_COUNT; k++)
				if (pick < 0 && !tbl_valid[k])
					pick = k;
			if (pick < 0) begin
				pick = 0;
				best_age = f.now - tbl_touch[0];
				for (int k = 1; k < SLOT_COUNT; k++) begin
					age = f.now - tbl_touch[k];
					if (age > best_age) begin
						best_age = age;
						pick = k;
					end
				end
			end
			clear_slot(pick);
			tbl_valid[pick] = 1'b1;
			tbl_seq[pick]   = f.seq;
			tbl_src[pick]   = f.src;
		end
		o.slot = pick[2:0];
		tbl_touch[pick] = f.now;
		if (tbl_total[pick] == 0) begin
			if (f.tot == 0 || f.tot > MAX_FRAGMENTS) begin
				clear_slot(pick);
				o.status = ST_BAD_COUNT;
				return o;
			end
			tbl_total[pick] = f.tot[6:0];
			tbl_rcvd[pick]  = '0;
		end else if (f.tot > tbl_total[pick] && f.tot <= MAX_FRAGMENTS) begin
			tbl_total[pick] = f.tot[6:0];
		end
		if (f.idx >= tbl_total[pick]) begin
			o.status = ST_RANGE;
			return o;
		end
		if (tbl_present[pick][f.idx[5:0]]) begin
			o.status = ST_DUPLICATE;
			return o;
		end
		tbl_present[pick][f.idx[5:0]] = 1'b1;
		tbl_rcvd[pick]    = tbl_rcvd[pick] + 7'd1;
		tbl_len_sum[pick] = tbl_len_sum[pick] + {6'd0, f.len};
		if (tbl_rcvd[pick] == tbl_total[pick]) begin
			o.status   = ST_COMPLETE;
			o.msg_len  = tbl_len_sum[pick];
			o.frag_cnt = tbl_total[pick];
			clear_slot(pick);
		end
		return o;
	endfunction

	// Every header transaction accepted by the block is run through the predictor here.
	always @(posedge clk) begin : header_monitor
		frag_t f;
		if (arst_n && s_tvalid && s_tready) begin
			f = s_tdata[107:0];
			predicted_outcomes.push_back(track_fragment(f));
		end
	end

	// Every result transaction is compared field by field with the oldest prediction.
	always @(posedge clk) begin : result_checker
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_outcomes.size() == 0) begin
				$error("result %h arrived with no fragment outstanding", m_tdata);
				fail_count++;
			end else begin
				want = predicted_outcomes.pop_front();
				if (m_tdata[2:0] != want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
					fail_count++;
				end
				if (m_tdata[5:3] != want.slot) begin
					$error("slot_used: expected %0d, got %0d", want.slot, m_tdata[5:3]);
					fail_count++;
				end
				if (m_tdata[23:6] != want.msg_len) begin
					$error("message_length: expected %0d, got %0d",
						want.msg_len, m_tdata[23:6]);
					fail_count++;
				end
				if (m_tdata[30:24] != want.frag_cnt) begin
					$error("fragment_count: expected %0d, got %0d",
						want.frag_cnt, m_tdata[30:24]);
					fail_count++;
				end
			end
		end
	end

	// Receiver side. It switches between stretches of full readiness, coin-toss readiness
	// and heavy stalling; a hold request from a test keeps it stalled for a counted stretch.
	initial begin : result_sink
		int run_left;
		int mode;
		int hold_left;
		run_left = 0;
		mode = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					mode = $urandom_range(0, 2);
					run_left = $urandom_range(10, 60);
				end
				run_left--;
				case (mode)
					0: begin
						m_tready <= 1'b1;
					end
					1: begin
						m_tready <= 1'($urandom_range(0, 1));
					end
					default: begin
						m_tready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// Offers one header and returns once the block has taken it. Headers go out in
	// bursts of random length separated by random gaps, unless the sender is held steady.
	task automatic send_fragment(input logic [31:0] now, input logic [15:0] seq,
		input logic [15:0] src, input logic [15:0] idx, input logic [15:0] tot,
		input logic [11:0] len);
		frag_t f;
		int    gap;
		f.now = now;
		f.seq = seq;
		f.src = src;
		f.idx = idx;
		f.tot = tot;
		f.len = len;
		@(negedge clk);
		if (burst_left == 0 && !sender_steady) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, f};
		do @(posedge clk); while (!s_tready);
	endtask

	// Withdraws the sender and waits until every predicted result has been seen, plus the
	// pipeline depth of the block so that nothing is left in flight.
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_expire(input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		expire_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Opens a new message in one of the traffic slots, with its fragments in random order.
	task automatic start_message(input int m);
		int r;
		int j;
		int t;
		open_seq[m] = $urandom_range(0, 65535);
		open_src[m] = $urandom_range(0, 65535);
		r = $urandom_range(0, 99);
		if (r < 80)
			open_tot[m] = $urandom_range(1, 8);
		else if (r < 95)
			open_tot[m] = $urandom_range(9, 32);
		else
			open_tot[m] = $urandom_range(33, 64);
		for (int i = 0; i < open_tot[m]; i++)
			open_order[m][i] = i;
		for (int i = open_tot[m] - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = open_order[m][i];
			open_order[m][i] = open_order[m][j];
			open_order[m][j] = t;
		end
		open_pos[m] = 0;
		open_live[m] = 1'b1;
	endtask

	// Moves the millisecond clock on: mostly small steps, sometimes past the idle limit,
	// now and then to an arbitrary point so that wrap-around and backward jumps occur.
	task automatic advance_clock();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			clock_ms = $urandom();
		else if (r < 6)
			clock_ms = clock_ms + expire_limit + $urandom_range(1, 100);
		else
			clock_ms = clock_ms + $urandom_range(0, 40);
	endtask

	// Empty fragments, first with every other field at its top value, then at zero: ignored, slot 0 reported.
	task automatic test_empty_fragment();
		send_fragment(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd0);
		send_fragment(32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0);
	endtask

	// A first fragment announcing no count or too many drops its slot again.
	task automatic test_bad_first_count();
		send_fragment(32'd10, 16'h0101, 16'h0001, 16'd0, 16'd0, 12'd5);
		send_fragment(32'd11, 16'h0102, 16'h0001, 16'd0, 16'd65, 12'd5);
		send_fragment(32'd12, 16'h0103, 16'h0001, 16'd0, 16'hFFFF, 12'd5);
	endtask

	// A duplicate, an out-of-range index, ignored smaller or bad counts and a grown count.
	task automatic test_count_rules();
		send_fragment(32'd20, 16'h0200, 16'h0002, 16'd0, 16'd3, 12'd100);
		send_fragment(32'd21, 16'h0200, 16'h0002, 16'd0, 16'd3, 12'd100);
		send_fragment(32'd22, 16'h0200, 16'h0002, 16'hFFFF, 16'd3, 12'd7);
		send_fragment(32'd23, 16'h0200, 16'h0002, 16'd1, 16'd2, 12'd200);
		send_fragment(32'd24, 16'h0200, 16'h0002, 16'd3, 16'd4, 12'd300);
		send_fragment(32'd25, 16'h0200, 16'h0002, 16'd2, 16'd0, 12'd400);
	endtask

	// A message of a single fragment completes at once with the largest length.
	task automatic test_single_fragment();
		send_fragment(32'd30, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 12'hFFF);
	endtask

	// Idle age across the wrap of the time counter, then a slot that times out and is
	// reused by a newcomer before the stale key comes back.
	task automatic test_expiry_and_wrap();
		send_fragment(32'hFFFF_FF00, 16'h0300, 16'h0003, 16'd0, 16'd2, 12'd50);
		send_fragment(32'h0000_0080, 16'h0300, 16'h0003, 16'd1, 16'd2, 12'd60);
		send_fragment(32'd1000, 16'h0301, 16'h0003, 16'd0, 16'd2, 12'd70);
		send_fragment(32'd2501, 16'h0302, 16'h0003, 16'd0, 16'd2, 12'd80);
		send_fragment(32'd2501, 16'h0301, 16'h0003, 16'd1, 16'd2, 12'd90);
	endtask

	// Fills every slot, the two oldest touched at the same time, then takes one over.
	task automatic test_eviction();
		logic [31:0] t0;
		t0 = 32'd10000;
		send_fragment(t0, 16'h0400, 16'h0004, 16'd0, 16'd2, 12'd1);
		send_fragment(t0, 16'h0401, 16'h0004, 16'd0, 16'd2, 12'd1);
		for (int i = 2; i < SLOT_COUNT; i++)
			send_fragment(t0 + i, 16'(i + 16'h0400), 16'h0004, 16'd0, 16'd2, 12'd1);
		send_fragment(t0 + 10, 16'h04FF, 16'h0004, 16'd0, 16'd2, 12'd1);
		clock_ms = t0 + 10;
	endtask

	// One random phase at a given idle limit. Most fragments belong to well-formed
	// messages; the rest are duplicates, bad indexes, bad counts, empties and noise.
	task automatic test_random_traffic(input logic [15:0] limit, input int n_items);
		int sent;
		int r;
		int m;
		int q;
		int idx;
		int tot;
		int len;
		wait_for_results();
		write_expire(limit);
		open_limit = $urandom_range(2, OPEN_MAX);
		for (int i = 0; i < OPEN_MAX; i++)
			open_live[i] = 1'b0;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			m = $urandom_range(0, open_limit - 1);
			if (!open_live[m])
				start_message(m);
			advance_clock();
			tot = open_tot[m];
			len = $urandom_range(1, 4095);
			if (r < 68) begin
				idx = open_order[m][open_pos[m]];
				q = $urandom_range(0, 19);
				if (open_pos[m] > 0) begin
					if (q == 0)
						tot = 0;
					else if (q == 1)
						tot = $urandom_range(65, 65535);
					else if (q == 2 && tot > 1)
						tot = $urandom_range(1, tot - 1);
				end else if (q == 0 && tot > 1) begin
					// Understated first count, to be grown by later fragments.
					tot = tot - 1;
				end
				send_fragment(clock_ms, 16'(open_seq[m]), 16'(open_src[m]), 16'(idx),
					16'(tot), 12'(len));
				open_pos[m]++;
				if (open_pos[m] == open_tot[m])
					open_live[m] = 1'b0;
				sent++;
			end else if (r < 76) begin
				idx = (open_pos[m] > 0) ? open_order[m][$urandom_range(0, open_pos[m] - 1)] : 0;
				send_fragment(clock_ms, 16'(open_seq[m]), 16'(open_src[m]), 16'(idx),
					16'(tot), 12'(len));
				sent++;
			end else if (r < 82) begin
				idx = $urandom_range(tot, 65535);
				send_fragment(clock_ms, 16'(open_seq[m]), 16'(open_src[m]), 16'(idx),
					16'(tot), 12'(len));
				sent++;
			end else if (r < 87) begin
				// Ignored by the block, so not counted.
				send_fragment($urandom(), 16'($urandom()), 16'($urandom()), 16'($urandom()),
					16'($urandom()), 12'd0);
			end else if (r < 93) begin
				tot = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 65535);
				send_fragment(clock_ms, 16'($urandom()), 16'($urandom()),
					16'($urandom_range(0, 65535)), 16'(tot), 12'(len));
				sent++;
			end else begin
				len = $urandom_range(0, 4095);
				send_fragment($urandom(), 16'($urandom()), 16'($urandom()), 16'($urandom()),
					16'($urandom()), 12'(len));
				if (len != 0)
					sent++;
			end
		end
	endtask

	// The largest message the block allows: all fragments, every one at full length.
	task automatic test_largest_message();
		int order [64];
		int j;
		int t;
		for (int i = 0; i < 64; i++)
			order[i] = i;
		for (int i = 63; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < 64; i++) begin
			clock_ms = clock_ms + $urandom_range(0, 5);
			send_fragment(clock_ms, 16'hA5A5, 16'h5A5A, 16'(order[i]), 16'(MAX_FRAGMENTS),
				12'hFFF);
		end
	endtask

	// The receiver stalls for a long stretch while headers keep coming, so the block
	// fills up and must hold off its input; afterwards the sender waits for every result.
	task automatic test_backpressure();
		wait_for_results();
		sender_steady = 1'b1;
		rx_hold_req = 400;
		for (int i = 0; i < 40; i++) begin
			clock_ms = clock_ms + 1;
			send_fragment(clock_ms, 16'(16'h7000 + i / 8), 16'h0077, 16'(i % 8), 16'd8,
				12'($urandom_range(1, 4095)));
		end
		sender_steady = 1'b0;
		wait_for_results();
	endtask

	initial begin : main_sequence
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		clock_ms  = '0;
		expire_limit = EXPIRE_RESET;
		for (int k = 0; k < SLOT_COUNT; k++)
			clear_slot(k);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_fragment();
		test_bad_first_count();
		test_count_rules();
		test_single_fragment();
		test_expiry_and_wrap();
		test_eviction();
		test_random_traffic(16'd0, 50);
		test_random_traffic(16'hFFFF, 130);
		test_largest_message();
		test_random_traffic(16'($urandom_range(1, 65534)), 130);
		test_backpressure();
		test_random_traffic(EXPIRE_RESET, 130);
		wait_for_results();

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
